FILE: sv/ttl_pkg.sv
// Shared types, register indexes and helpers for the target track lifecycle core.
// No dependencies; imported by every module of the core.
package ttl_pkg;

   // Tracking modes, also the encoding of the reported track state
   typedef enum logic [2:0] {
      MODE_LOST    = 3'd0,
      MODE_DETECT  = 3'd1,
      MODE_TRACK   = 3'd2,
      MODE_TEMP    = 3'd3,
      MODE_SWITCH  = 3'd4
   } ttl_mode_type;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DETECT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_LOST   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPOST_LOST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_TMO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OMNI_MODE     = 3'd5;

   // Reset values of the configuration registers
   localparam logic [7:0]  MIN_DETECT_RST   = 8'd5;
   localparam logic [7:0]  NORMAL_LOST_RST  = 8'd100;
   localparam logic [7:0]  OUTPOST_LOST_RST = 8'd200;
   localparam logic [7:0]  SWITCH_TMO_RST   = 8'd200;
   localparam logic [15:0] GAP_LIMIT_RST    = 16'd100;
   localparam logic [2:0]  WANTED_PRIO_RST  = 3'd5;

   // Input transaction
   typedef struct packed {
      logic [15:0] elapsed_ms;
      logic        main_present;
      logic [2:0]  main_priority;
      logic        main_is_outpost;
      logic        match_present;
      logic        omni_present;
      logic [2:0]  omni_priority;
      logic        converged;
      logic        diverged;
      logic        bad_fit;
   } ttl_req_type;

   // Result transaction
   typedef struct packed {
      logic [2:0] track_state;
      logic       target_valid;
      logic       new_target;
      logic       switch_request;
      logic [2:0] switch_priority;
   } ttl_rsp_type;

   // Configuration register set
   typedef struct packed {
      logic [7:0]  confirm_needed;
      logic [7:0]  normal_lost_limit;
      logic [7:0]  outpost_lost_limit;
      logic [7:0]  switch_timeout;
      logic [15:0] gap_limit_ms;
      logic        omni_mode;
   } ttl_cfg_type;

   // Tracker state carried from frame to frame
   typedef struct packed {
      ttl_mode_type mode;
      ttl_mode_type prev_mode;
      logic [7:0]   confirm_count;
      logic [7:0]   coast_count;
      logic [2:0]   held_priority;
      logic         held_is_outpost;
      logic [2:0]   wanted_priority;
   } ttl_state_type;

   // Counter increment that stops at all ones
   function automatic logic [7:0] sat_inc(input logic [7:0] c);
      logic [7:0] r;
      r = (c == 8'hFF) ? c : c + 8'd1;
      return r;
   endfunction

endpackage

FILE: sv/ttl_step.sv
// Per-frame decision logic: next tracker state and the frame's result.
// Purely combinational; depends on ttl_pkg.
module ttl_step (
   input  ttl_pkg::ttl_state_type cur_state,
   input  ttl_pkg::ttl_cfg_type   cfg,
   input  ttl_pkg::ttl_req_type   req,
   output ttl_pkg::ttl_state_type nxt_state,
   output ttl_pkg::ttl_rsp_type   rsp
);
   import ttl_pkg::*;

   ttl_mode_type mode_gap;     // after frame gap check
   ttl_mode_type mode_sel;     // after omni branch (may enter switching)
   ttl_mode_type mode_adv;     // after confirm/coast advance
   ttl_mode_type mode_fin;     // after divergence / bad-fit override
   logic         found;
   logic         take_main;
   logic         fresh;
   logic         sw_start;
   logic [2:0]   wanted_nxt;
   logic [2:0]   held_prio_nxt;
   logic         held_outpost_nxt;
   logic [7:0]   confirm_nxt;
   logic [7:0]   coast_nxt;
   logic [7:0]   confirm_inc;
   logic [7:0]   coast_inc;
   logic [7:0]   lost_lim;

   // Frame gap drops any held target
   always_comb begin
      mode_gap = cur_state.mode;
      if ((cur_state.mode != MODE_LOST) && (req.elapsed_ms > cfg.gap_limit_ms)) begin
         mode_gap = MODE_LOST;
      end
   end

   // Candidate selection: what counts as found this frame
   always_comb begin
      take_main  = 1'b0;
      sw_start   = 1'b0;
      found      = req.match_present;
      mode_sel   = mode_gap;
      wanted_nxt = cur_state.wanted_priority;
      if (!cfg.omni_mode) begin
         if (mode_gap == MODE_LOST) begin
            take_main = 1'b1;
         end
      end else begin
         priority if (mode_gap == MODE_LOST) begin
            take_main = 1'b1;
         end else if ((mode_gap == MODE_TRACK) && req.main_present &&
                      (req.main_priority < cur_state.held_priority)) begin
            take_main = 1'b1;
         end else if ((mode_gap == MODE_TRACK) && req.omni_present &&
                      (req.omni_priority < cur_state.held_priority) && req.converged) begin
            mode_sel   = MODE_SWITCH;
            wanted_nxt = req.omni_priority;
            sw_start   = 1'b1;
            found      = 1'b0;
         end else if (mode_gap == MODE_SWITCH) begin
            found = req.main_present && (req.main_priority == cur_state.wanted_priority);
         end else if ((mode_gap == MODE_DETECT) && (cur_state.prev_mode == MODE_SWITCH)) begin
            take_main = 1'b1;
         end else begin
            found = req.match_present;
         end
      end
      if (take_main) begin
         found = req.main_present;
      end
   end

   assign fresh            = take_main && req.main_present;
   assign held_prio_nxt    = fresh ? req.main_priority : cur_state.held_priority;
   assign held_outpost_nxt = fresh ? req.main_is_outpost : cur_state.held_is_outpost;
   assign confirm_inc      = sat_inc(cur_state.confirm_count);
   assign coast_inc        = sat_inc(cur_state.coast_count);
   assign lost_lim         = held_outpost_nxt ? cfg.outpost_lost_limit
                                              : cfg.normal_lost_limit;

   // Confirm / coast advance
   always_comb begin
      mode_adv    = mode_sel;
      confirm_nxt = cur_state.confirm_count;
      coast_nxt   = cur_state.coast_count;
      unique case (mode_sel)
         MODE_LOST: begin
            if (found) begin
               mode_adv    = MODE_DETECT;
               confirm_nxt = 8'd1;
            end
         end
         MODE_DETECT: begin
            if (found) begin
               confirm_nxt = confirm_inc;
               if (confirm_inc >= cfg.confirm_needed) begin
                  mode_adv = MODE_TRACK;
               end
            end else begin
               confirm_nxt = 8'd0;
               mode_adv    = MODE_LOST;
            end
         end
         MODE_TRACK: begin
            if (!found) begin
               coast_nxt = 8'd1;
               mode_adv  = MODE_TEMP;
            end
         end
         MODE_SWITCH: begin
            if (found) begin
               mode_adv = MODE_DETECT;
            end else begin
               coast_nxt = coast_inc;
               if (coast_inc > cfg.switch_timeout) begin
                  mode_adv = MODE_LOST;
               end
            end
         end
         MODE_TEMP: begin
            if (found) begin
               mode_adv = MODE_TRACK;
            end else begin
               coast_nxt = coast_inc;
               if (coast_inc > lost_lim) begin
                  mode_adv = MODE_LOST;
               end
            end
         end
         default: begin
            mode_adv = MODE_LOST;
         end
      endcase
   end

   // Divergence always drops; bad fit drops in plain mode
   always_comb begin
      mode_fin = mode_adv;
      if (req.diverged) begin
         mode_fin = MODE_LOST;
      end
      if (!cfg.omni_mode && req.bad_fit) begin
         mode_fin = MODE_LOST;
      end
   end

   // Next state
   always_comb begin
      nxt_state.mode            = mode_fin;
      nxt_state.prev_mode       = cfg.omni_mode ? mode_sel : cur_state.prev_mode;
      nxt_state.confirm_count   = confirm_nxt;
      nxt_state.coast_count     = coast_nxt;
      nxt_state.held_priority   = held_prio_nxt;
      nxt_state.held_is_outpost = held_outpost_nxt;
      nxt_state.wanted_priority = wanted_nxt;
   end

   // Frame result
   always_comb begin
      rsp.track_state     = mode_fin;
      rsp.target_valid    = (mode_fin != MODE_LOST);
      rsp.new_target      = fresh;
      rsp.switch_request  = sw_start;
      rsp.switch_priority = sw_start ? wanted_nxt : 3'd0;
   end

endmodule

FILE: sv/target_track_lifecycle_core.sv
// Top level of the target track lifecycle core: channel registers, state, CSRs.
// Depends on ttl_pkg and ttl_step.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | ttl_req_type, one frame
//   rsp_    | out       | rsp_valid/rsp_stall | ttl_rsp_type, one result per frame
//   csr_    | in        | csr_we              | csr_index, csr_wdata
//
// Each frame passes from acceptance through the input register, then through
// one pass of the decision logic into the result register, which also updates
// the tracker state. One frame is accepted every cycle while rsp_stall is low.
// A stalled result holds; the input register then fills and req_stall rises.
// Synchronous reset clears control state, the tracker state and the CSRs.
module target_track_lifecycle_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ttl_pkg::ttl_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ttl_pkg::ttl_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [ttl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ttl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ttl_pkg::*;

   logic          in_valid_ff;
   ttl_req_type   in_data_ff;
   logic          out_valid_ff;
   ttl_rsp_type   out_data_ff;
   ttl_state_type state_ff;
   ttl_state_type state_in;
   ttl_rsp_type   rsp_in;
   ttl_cfg_type   cfg_ff;
   logic          out_free;
   logic          advance;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Decision logic
   ttl_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .req       (in_data_ff),
      .nxt_state (state_in),
      .rsp       (rsp_in)
   );

   // Result register and tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_LOST, prev_mode: MODE_LOST, confirm_count: 8'd0,
                           coast_count: 8'd0, held_priority: 3'd0,
                           held_is_outpost: 1'b0, wanted_priority: WANTED_PRIO_RST};
      end else if (advance) begin
         out_valid_ff <= 1'b1;
         state_ff     <= state_in;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   // Configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{confirm_needed: MIN_DETECT_RST, normal_lost_limit: NORMAL_LOST_RST,
                     outpost_lost_limit: OUTPOST_LOST_RST, switch_timeout: SWITCH_TMO_RST,
                     gap_limit_ms: GAP_LIMIT_RST, omni_mode: 1'b0};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_DETECT:   cfg_ff.confirm_needed     <= csr_wdata[7:0];
            CSR_NORMAL_LOST:  cfg_ff.normal_lost_limit  <= csr_wdata[7:0];
            CSR_OUTPOST_LOST: cfg_ff.outpost_lost_limit <= csr_wdata[7:0];
            CSR_SWITCH_TMO:   cfg_ff.switch_timeout     <= csr_wdata[7:0];
            CSR_GAP_LIMIT:    cfg_ff.gap_limit_ms       <= csr_wdata;
            CSR_OMNI_MODE:    cfg_ff.omni_mode          <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: sv/ttl_checker.sv
// Port-level checks on the target track lifecycle core, bound to the top level.
// Depends on ttl_pkg.
module ttl_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ttl_pkg::ttl_rsp_type rsp_data
);
   import ttl_pkg::*;

   // A stalled result transaction stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Target reported exactly when not lost
   a_valid_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.target_valid == (rsp_data.track_state != MODE_LOST)))
      else $error("target_valid disagrees with track_state");

   // Switch priority is zero without a switch request
   a_sw_prio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.switch_request |-> (rsp_data.switch_priority == 3'd0))
      else $error("switch_priority set without switch_request");

   // A switch request leaves the tracker switching or lost
   a_sw_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.switch_request |->
         (rsp_data.track_state == MODE_SWITCH) || (rsp_data.track_state == MODE_LOST))
      else $error("switch request with unexpected state");

   // A new target is never coasting or switching in the same frame
   a_new_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_target |->
         (rsp_data.track_state != MODE_TEMP) && (rsp_data.track_state != MODE_SWITCH))
      else $error("new target with coasting or switching state");

endmodule

bind target_track_lifecycle_core ttl_checker u_ttl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for target_track_lifecycle_core: directed table, then random frames.
// Depends on ttl_pkg and the core; results are checked against a frame-level tracker model.
`timescale 1ns / 100ps

module testbench;
   import ttl_pkg::*;

   // Indexes past the end of the register list; writes to them are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   ttl_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   ttl_rsp_type           rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   target_track_lifecycle_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Directed stimulus row: a register write or a frame, optionally with a typed result
   typedef struct {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] wdata;
      ttl_req_type           frame;
      logic                  typed;
      ttl_rsp_type           due;
   } directed_row_type;

   directed_row_type directed_rows[$];
   ttl_rsp_type      results_due[$];
   ttl_rsp_type      oldest_due;
   int               error_count;
   int               frames_accepted;
   int               results_seen;
   int               burst_left;
   int               sight_left;
   logic             in_sight;

   // Tracker model: configuration copy and the state carried between frames
   ttl_cfg_type      regs;
   ttl_mode_type     trk_mode;
   ttl_mode_type     trk_prev;
   logic [7:0]       confirm_cnt;
   logic [7:0]       coast_cnt;
   logic [2:0]       held_prio;
   logic             held_outpost;
   logic [2:0]       wanted_prio;

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic flag_error(input string msg);
      error_count++;
      $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         flag_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // One frame decision of the tracker; updates the model state and returns the result
   function automatic ttl_rsp_type decide_frame(input ttl_req_type f);
      ttl_rsp_type r;
      logic        found;
      logic        fresh;
      logic        swr;
      logic [7:0]  lim;
      found = 1'b0;
      fresh = 1'b0;
      swr   = 1'b0;
      // long frame gap drops whatever is held
      if (trk_mode != MODE_LOST && f.elapsed_ms > regs.gap_limit_ms) trk_mode = MODE_LOST;
      // does this frame confirm the held target, or bring a new one
      if (trk_mode == MODE_LOST) begin
         found = f.main_present;
         fresh = f.main_present;
      end else if (!regs.omni_mode) begin
         found = f.match_present;
      end else if (trk_mode == MODE_TRACK && f.main_present && f.main_priority < held_prio) begin
         found = 1'b1;
         fresh = 1'b1;
      end else if (trk_mode == MODE_TRACK && f.omni_present && f.omni_priority < held_prio
                   && f.converged) begin
         trk_mode    = MODE_SWITCH;
         wanted_prio = f.omni_priority;
         swr         = 1'b1;
      end else if (trk_mode == MODE_SWITCH) begin
         found = f.main_present && f.main_priority == wanted_prio;
      end else if (trk_mode == MODE_DETECT && trk_prev == MODE_SWITCH) begin
         found = f.main_present;
         fresh = f.main_present;
      end else begin
         found = f.match_present;
      end
      if (fresh) begin
         held_prio    = f.main_priority;
         held_outpost = f.main_is_outpost;
      end
      // history is kept in omni mode only
      if (regs.omni_mode) trk_prev = trk_mode;
      // state transition, counters saturate at all ones
      case (trk_mode)
         MODE_LOST: begin
            if (found) begin
               trk_mode    = MODE_DETECT;
               confirm_cnt = 8'd1;
            end
         end
         MODE_DETECT: begin
            if (found) begin
               if (confirm_cnt != 8'hFF) confirm_cnt = confirm_cnt + 8'd1;
               if (confirm_cnt >= regs.confirm_needed) trk_mode = MODE_TRACK;
            end else begin
               confirm_cnt = 8'd0;
               trk_mode    = MODE_LOST;
            end
         end
         MODE_TRACK: begin
            if (!found) begin
               coast_cnt = 8'd1;
               trk_mode  = MODE_TEMP;
            end
         end
         MODE_SWITCH: begin
            if (found) begin
               trk_mode = MODE_DETECT;
            end else begin
               if (coast_cnt != 8'hFF) coast_cnt = coast_cnt + 8'd1;
               if (coast_cnt > regs.switch_timeout) trk_mode = MODE_LOST;
            end
         end
         MODE_TEMP: begin
            if (found) begin
               trk_mode = MODE_TRACK;
            end else begin
               lim = held_outpost ? regs.outpost_lost_limit : regs.normal_lost_limit;
               if (coast_cnt != 8'hFF) coast_cnt = coast_cnt + 8'd1;
               if (coast_cnt > lim) trk_mode = MODE_LOST;
            end
         end
         default: trk_mode = MODE_LOST;
      endcase
      if (trk_mode != MODE_LOST && f.diverged) trk_mode = MODE_LOST;
      if (!regs.omni_mode && f.bad_fit) trk_mode = MODE_LOST;
      r.track_state     = trk_mode;
      r.target_valid    = (trk_mode != MODE_LOST);
      r.new_target      = fresh;
      r.switch_request  = swr;
      r.switch_priority = swr ? wanted_prio : 3'd0;
      return r;
   endfunction

   function automatic ttl_req_type frame_of(input logic [15:0] el, input logic mp,
                                            input logic [2:0] mpr, input logic mo,
                                            input logic mt, input logic op,
                                            input logic [2:0] opr, input logic cv,
                                            input logic dv, input logic bf);
      ttl_req_type f;
      f.elapsed_ms      = el;
      f.main_present    = mp;
      f.main_priority   = mpr;
      f.main_is_outpost = mo;
      f.match_present   = mt;
      f.omni_present    = op;
      f.omni_priority   = opr;
      f.converged       = cv;
      f.diverged        = dv;
      f.bad_fit         = bf;
      return f;
   endfunction

   function automatic ttl_rsp_type result_of(input ttl_mode_type m, input logic tv,
                                             input logic nt, input logic sr,
                                             input logic [2:0] sp);
      ttl_rsp_type r;
      r.track_state     = m;
      r.target_valid    = tv;
      r.new_target      = nt;
      r.switch_request  = sr;
      r.switch_priority = sp;
      return r;
   endfunction

   function automatic void add_frame(input ttl_req_type f);
      directed_row_type row;
      row.is_write = 1'b0;
      row.idx      = '0;
      row.wdata    = '0;
      row.frame    = f;
      row.typed    = 1'b0;
      row.due      = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed(input ttl_req_type f, input ttl_rsp_type due);
      directed_row_type row;
      row.is_write = 1'b0;
      row.idx      = '0;
      row.wdata    = '0;
      row.frame    = f;
      row.typed    = 1'b1;
      row.due      = due;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      directed_row_type row;
      row.is_write = 1'b1;
      row.idx      = idx;
      row.wdata    = val;
      row.frame    = '0;
      row.typed    = 1'b0;
      row.due      = '0;
      directed_rows.push_back(row);
   endfunction

   // Limit or count: the floor, all ones, or a small value
   function automatic logic [7:0] pick_count(input logic [7:0] floor);
      case ($urandom_range(0, 4))
         0:       return floor;
         1:       return 8'hFF;
         default: return 8'($urandom_range(floor + 1, 12));
      endcase
   endfunction

   // Random frame: runs of the target in and out of view, with rare upsets and some noise
   function automatic ttl_req_type random_frame();
      ttl_req_type f;
      if (sight_left == 0) begin
         in_sight   = ($urandom_range(0, 2) != 0);
         sight_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 300)
                                                   : $urandom_range(1, 12);
      end
      sight_left--;
      f = ttl_req_type'($urandom);
      if ($urandom_range(0, 9) == 0) return f;
      if ($urandom_range(0, 23) != 0)
         f.elapsed_ms = 16'($urandom_range(0, regs.gap_limit_ms));
      f.match_present = in_sight;
      f.main_present  = in_sight ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
      if (trk_mode == MODE_SWITCH && in_sight && $urandom_range(0, 1))
         f.main_priority = wanted_prio;
      f.omni_present = ($urandom_range(0, 2) == 0);
      f.diverged     = ($urandom_range(0, 47) == 0);
      f.bad_fit      = ($urandom_range(0, 47) == 0);
      return f;
   endfunction

   // Sender bursts: a random gap before each burst, sometimes none
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // Offer one frame and hold it until the core takes the transaction
   task automatic offer(input ttl_req_type f, input logic typed, input ttl_rsp_type due);
      ttl_rsp_type want;
      pace();
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= f;
      do @(posedge clock); while (req_stall);
      want = decide_frame(f);
      results_due.push_back(typed ? due : want);
      frames_accepted++;
   endtask

   // Stop sending and wait for every outstanding result
   task automatic settle_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (results_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MIN_DETECT:   regs.confirm_needed     = val[7:0];
         CSR_NORMAL_LOST:  regs.normal_lost_limit  = val[7:0];
         CSR_OUTPOST_LOST: regs.outpost_lost_limit = val[7:0];
         CSR_SWITCH_TMO:   regs.switch_timeout     = val[7:0];
         CSR_GAP_LIMIT:    regs.gap_limit_ms       = val;
         CSR_OMNI_MODE:    regs.omni_mode          = val[0];
         default: ;
      endcase
      @(negedge clock) csr_we <= 1'b0;
   endtask

   // Result side: stall segments of differing character, and one long hold-off
   initial begin
      int   seg_kind;
      int   seg_len;
      logic held_once;
      rsp_stall = 1'b0;
      held_once = 1'b0;
      forever begin
         if (!held_once && frames_accepted >= 210) begin
            held_once = 1'b1;
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (79) @(negedge clock);
         end
         seg_kind = $urandom_range(0, 3);
         seg_len  = $urandom_range(5, 60);
         for (int n = 0; n < seg_len; n++) begin
            @(negedge clock);
            case (seg_kind)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ((n % 5) < 2);
               default: rsp_stall <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // Result checker: every transaction taken is compared with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (results_due.size() == 0) begin
            flag_error("result with no frame outstanding");
         end else begin
            oldest_due = results_due.pop_front();
            check_field("track_state", 8'(rsp_data.track_state),
                        8'(oldest_due.track_state));
            check_field("target_valid", 8'(rsp_data.target_valid),
                        8'(oldest_due.target_valid));
            check_field("new_target", 8'(rsp_data.new_target), 8'(oldest_due.new_target));
            check_field("switch_request", 8'(rsp_data.switch_request),
                        8'(oldest_due.switch_request));
            check_field("switch_priority", 8'(rsp_data.switch_priority),
                        8'(oldest_due.switch_priority));
         end
      end
   end

   // Main sequence
   initial begin
      ttl_req_type           f;
      logic [7:0]            hi;
      logic [CSR_DATA_W-1:0] gapv;
      int                    wait_cycles;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      error_count     = 0;
      frames_accepted = 0;
      results_seen    = 0;
      burst_left      = 0;
      sight_left      = 0;
      in_sight        = 1'b0;

      regs.confirm_needed     = MIN_DETECT_RST;
      regs.normal_lost_limit  = NORMAL_LOST_RST;
      regs.outpost_lost_limit = OUTPOST_LOST_RST;
      regs.switch_timeout     = SWITCH_TMO_RST;
      regs.gap_limit_ms       = GAP_LIMIT_RST;
      regs.omni_mode          = 1'b0;
      trk_mode     = MODE_LOST;
      trk_prev     = MODE_LOST;
      confirm_cnt  = 8'd0;
      coast_cnt    = 8'd0;
      held_prio    = 3'd0;
      held_outpost = 1'b0;
      wanted_prio  = WANTED_PRIO_RST;

      // plain mode at reset values: acquire, gap drop, divergence, bad fit
      add_typed(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), result_of(MODE_LOST, 0, 0, 0, 0));
      add_typed(frame_of(100, 1, 7, 1, 0, 0, 0, 0, 0, 0), result_of(MODE_DETECT, 1, 1, 0, 0));
      add_typed(frame_of(101, 0, 0, 0, 0, 0, 0, 0, 0, 0), result_of(MODE_LOST, 0, 0, 0, 0));
      add_typed(frame_of(0, 1, 0, 0, 0, 0, 0, 0, 0, 0), result_of(MODE_DETECT, 1, 1, 0, 0));
      add_typed(frame_of(5, 0, 0, 0, 1, 0, 0, 0, 1, 0), result_of(MODE_LOST, 0, 0, 0, 0));
      add_typed(frame_of(5, 1, 5, 0, 0, 0, 0, 0, 0, 1), result_of(MODE_LOST, 0, 1, 0, 0));
      // fastest confirm, zero coast allowance, widest gap, writes past the list
      add_write(CSR_MIN_DETECT, 16'hA501);
      add_write(CSR_NORMAL_LOST, 16'h5A00);
      add_write(CSR_GAP_LIMIT, 16'hFFFF);
      add_write(CSR_UNUSED_LO, 16'h1234);
      add_write(CSR_UNUSED_HI, 16'hFFFF);
      add_frame(frame_of(16'hFFFF, 1, 3, 0, 0, 1, 7, 1, 0, 0));
      add_frame(frame_of(20, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      add_frame(frame_of(20, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_frame(frame_of(20, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // omni rules: better main target, switch and return, switch timeout
      add_write(CSR_OMNI_MODE, 16'h0001);
      add_write(CSR_SWITCH_TMO, 16'h00FF);
      add_write(CSR_NORMAL_LOST, 16'h00FF);
      add_write(CSR_OUTPOST_LOST, 16'hFFFF);
      add_frame(frame_of(10, 1, 4, 1, 0, 0, 0, 0, 0, 0));
      add_frame(frame_of(10, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      add_frame(frame_of(10, 1, 2, 0, 1, 0, 0, 0, 0, 0));
      add_typed(frame_of(10, 0, 0, 0, 1, 1, 1, 1, 0, 0), result_of(MODE_SWITCH, 1, 0, 1, 1));
      add_frame(frame_of(10, 1, 1, 0, 0, 0, 0, 0, 0, 0));
      add_frame(frame_of(10, 1, 6, 1, 0, 0, 0, 0, 0, 0));
      add_frame(frame_of(10, 0, 0, 0, 0, 1, 0, 1, 0, 0));
      add_write(CSR_SWITCH_TMO, 16'h0000);
      add_frame(frame_of(10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // divergence and bad fit have no effect while lost in omni mode
      add_typed(frame_of(10, 0, 0, 0, 0, 0, 0, 0, 1, 1), result_of(MODE_LOST, 0, 0, 0, 0));
      // slowest confirm and a zero gap limit
      add_write(CSR_MIN_DETECT, 16'h00FF);
      add_write(CSR_GAP_LIMIT, 16'h0000);
      add_frame(frame_of(0, 1, 3, 0, 0, 0, 0, 0, 0, 0));
      add_typed(frame_of(1, 0, 0, 0, 1, 0, 0, 0, 0, 0), result_of(MODE_LOST, 0, 0, 0, 0));
      add_frame(frame_of(16'hFFFF, 1, 7, 1, 1, 1, 7, 1, 1, 1));

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_write) begin
            settle_idle();
            write_reg(directed_rows[r].idx, directed_rows[r].wdata);
         end else begin
            offer(directed_rows[r].frame, directed_rows[r].typed, directed_rows[r].due);
         end
      end

      // random phases, each with a fresh register setting; plain and omni alternate
      for (int phase = 0; phase < 6; phase++) begin
         settle_idle();
         hi = 8'($urandom);
         case ($urandom_range(0, 3))
            0:       gapv = 16'h0000;
            1:       gapv = 16'hFFFF;
            default: gapv = 16'($urandom_range(20, 400));
         endcase
         write_reg(CSR_MIN_DETECT, {hi, pick_count(8'd1)});
         write_reg(CSR_NORMAL_LOST, {hi, pick_count(8'd0)});
         write_reg(CSR_OUTPOST_LOST, {~hi, pick_count(8'd0)});
         write_reg(CSR_SWITCH_TMO, {hi, pick_count(8'd0)});
         write_reg(CSR_GAP_LIMIT, gapv);
         write_reg(CSR_OMNI_MODE, {hi, 7'($urandom), phase[0]});
         if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CSR_UNUSED_LO : CSR_UNUSED_HI, 16'($urandom));
         repeat (90) offer(random_frame(), 1'b0, '0);
      end

      // long coasts with limits at all ones: the coast counter saturates and never passes
      for (int om = 0; om < 2; om++) begin
         settle_idle();
         write_reg(CSR_MIN_DETECT, 16'd1);
         write_reg(CSR_NORMAL_LOST, 16'd255);
         write_reg(CSR_OUTPOST_LOST, 16'd255);
         write_reg(CSR_SWITCH_TMO, 16'd255);
         write_reg(CSR_GAP_LIMIT, 16'hFFFF);
         write_reg(CSR_OMNI_MODE, 16'(om));
         offer(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0);
         offer(frame_of(0, 1, 7, om[0], 0, 0, 0, 0, 0, 0), 1'b0, '0);
         offer(frame_of(0, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1'b0, '0);
         if (om != 0) offer(frame_of(0, 0, 0, 0, 0, 1, 0, 1, 0, 0), 1'b0, '0);
         repeat (300) begin
            f = ttl_req_type'($urandom);
            f.match_present = 1'b0;
            f.diverged      = 1'b0;
            f.bad_fit       = 1'b0;
            if (om != 0) f.main_present = 1'b0;
            offer(f, 1'b0, '0);
         end
         offer(frame_of(0, 1, 0, 0, 1, 0, 0, 0, 0, 0), 1'b0, '0);
      end

      // drain, then allow for any stray result
      @(negedge clock) req_valid <= 1'b0;
      wait_cycles = 0;
      while (results_due.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (results_due.size() != 0)
         flag_error($sformatf("%0d results never arrived", results_due.size()));
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/ttl_pkg.sv
sv/ttl_step.sv
sv/target_track_lifecycle_core.sv
sv/ttl_checker.sv
tb/sv/testbench.sv
